/* src/mpit_pkg.sv */
// Shared types and constants of the multichannel pump interval timer.
package mpit_pkg;

  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_TRIG   = 3'd1;
  localparam logic [2:0] REQ_STOP   = 3'd2;
  localparam logic [2:0] REQ_RELOAD = 3'd3;
  localparam logic [2:0] REQ_QUERY  = 3'd4;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_IDLE   = 2'd1;
  localparam logic [1:0] MODE_MANUAL = 2'd2;
  localparam logic [1:0] MODE_AUTO   = 2'd3;

  localparam logic [7:0] CFG_INTERVAL = 8'd0;
  localparam logic [7:0] CFG_PUMP     = 8'd1;

  localparam logic [31:0] INTERVAL_RST = 32'd86400000;
  localparam logic [31:0] PUMP_RST     = 32'd30000;
  localparam logic [31:0] WATER_RST    = 32'd86370000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] timer;
  } chan_rec_t;

  typedef struct packed {
    chan_rec_t   rec;
    logic        ok;
    logic        water_wr;
    logic [31:0] water;
  } alu_res_t;

endpackage

/* src/mpit_chan_mem.sv */
// Channel state memory: mode and pump countdown per channel, registered read.
module mpit_chan_mem #(
  parameter int CHANNELS = 4,
  parameter int IW       = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [IW-1:0]       rd_addr,
  output mpit_pkg::chan_rec_t rd_rec,
  input  logic                wr_en,
  input  logic [IW-1:0]       wr_addr,
  input  mpit_pkg::chan_rec_t wr_rec
);

  mpit_pkg::chan_rec_t mem_r [CHANNELS];
  mpit_pkg::chan_rec_t rd_data_r;
  logic [CHANNELS-1:0] vld_r;
  logic                rd_vld_r;

  // entries never written read back as idle with an empty countdown
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_rec;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_comb begin
    if (rd_vld_r) begin
      rd_rec = rd_data_r;
    end else begin
      rd_rec.mode  = mpit_pkg::MODE_IDLE;
      rd_rec.timer = '0;
    end
  end

endmodule

/* src/mpit_chan_alu.sv */
// Per-channel update rules for tick, trigger and stop.
module mpit_chan_alu (
  input  logic [2:0]          req,
  input  logic [31:0]         delta,
  input  logic [31:0]         water,
  input  logic [31:0]         pump_dur,
  input  logic [31:0]         reload,
  input  mpit_pkg::chan_rec_t rec,
  output mpit_pkg::alu_res_t  res
);

  logic [31:0] t_dec;
  logic        pumping;

  assign t_dec   = (rec.timer > delta) ? (rec.timer - delta) : '0;
  assign pumping = (rec.mode == mpit_pkg::MODE_MANUAL) || (rec.mode == mpit_pkg::MODE_AUTO);

  always_comb begin
    res.rec      = rec;
    res.ok       = 1'b0;
    res.water_wr = 1'b0;
    res.water    = water;
    unique case (req)
      mpit_pkg::REQ_TICK: begin
        res.rec.timer = t_dec;
        if (rec.mode == mpit_pkg::MODE_IDLE) begin
          if (water == '0) begin
            res.rec.mode  = mpit_pkg::MODE_AUTO;
            res.rec.timer = pump_dur;
            res.water_wr  = 1'b1;
            res.water     = '0;
            res.ok        = 1'b1;
          end
        end else if (pumping && (t_dec == '0)) begin
          res.rec.mode = mpit_pkg::MODE_IDLE;
          res.water_wr = 1'b1;
          res.water    = reload;
          res.ok       = 1'b1;
        end
      end
      mpit_pkg::REQ_TRIG: begin
        if (rec.mode == mpit_pkg::MODE_IDLE) begin
          res.rec.mode  = mpit_pkg::MODE_MANUAL;
          res.rec.timer = pump_dur;
          res.ok        = 1'b1;
        end
      end
      mpit_pkg::REQ_STOP: begin
        // mode code 0 counts as not idle and may be stopped
        if (rec.mode != mpit_pkg::MODE_IDLE) begin
          res.rec.mode  = mpit_pkg::MODE_IDLE;
          res.rec.timer = '0;
          res.water_wr  = 1'b1;
          res.water     = reload;
          res.ok        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/multichannel_pump_interval_timer_core.sv */
// Top level of the multichannel pump interval timer: sequencer and ports.
//
// Input beats carry one request (tick, manual trigger, stop, reload of the
// watering countdown, query); every request yields exactly one result beat
// with ok, the addressed channel's mode and pump time, the watering
// countdown and a mask of pumping channels.
// Channel modes and pump countdowns live in a small synchronous memory.
// A tick or an all-channel trigger/stop walks the channels one per cycle:
// the read of channel c+1 overlaps the update and write-back of channel c.
// A single-channel trigger or stop visits only its own channel; reload,
// query and unknown requests do not walk the memory. Input reopens the
// cycle after a result loads. One request is in flight at a time;
// in_tready is high only between requests. A finished result sits in
// the output register while the next request is taken; if out_tready
// stays low, the next result waits for the register to empty and input
// is held off meanwhile.
// Configuration writes (cfg_ready always high) belong between requests, though
// the block does not enforce it; a write of zero is ignored. Reset idles all
// channels at once through per-entry valid bits, so no clearing pass is needed.
module multichannel_pump_interval_timer_core #(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] req_type, [3] all_channels, [7:4] channel, [39:8] tick_delta
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] ok, [2:1] chan_state, [34:3] chan_pump_left, [66:35] watering_left,
  // [70:67] pumping_mask
  output logic [71:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW = (CHANNELS > 4) ? CHANNELS : 4;
  localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RPT  = 2'd2;
  localparam logic [1:0] S_RD   = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [2:0]          req_r, req_nxt;
  logic [3:0]          ch_r, ch_nxt;
  logic                ch_ok_r, ch_ok_nxt;
  logic [31:0]         delta_r, delta_nxt;
  logic                ok_r, ok_nxt;
  logic [31:0]         water_r, water_nxt;
  logic [31:0]         interval_r, interval_nxt;
  logic [31:0]         pump_r, pump_nxt;
  logic [CHANNELS-1:0] pumping_r, pumping_nxt;
  logic [IW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]       last_r, last_nxt;
  logic                rd_more_r, rd_more_nxt;
  logic                proc_v_r, proc_v_nxt;
  logic [IW-1:0]       proc_idx_r, proc_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [71:0]         out_data_r;
  logic                out_load;

  logic [2:0]  in_req;
  logic        in_all;
  logic [3:0]  in_ch;
  logic [31:0] in_delta;
  logic        in_ch_ok;
  logic        accept;
  logic [31:0] reload;
  logic [31:0] water_dec;

  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  mpit_pkg::chan_rec_t rd_rec;
  logic                wr_en;
  mpit_pkg::alu_res_t  alu_res;
  logic [PW-1:0]       pumping_ext;
  logic [1:0]          rpt_mode;
  logic [31:0]         rpt_timer;

  assign in_req   = in_tdata[2:0];
  assign in_all   = in_tdata[3];
  assign in_ch    = in_tdata[7:4];
  assign in_delta = in_tdata[39:8];
  assign in_ch_ok = {1'b0, in_ch} < 5'(CHANNELS);

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign reload    = (pump_r >= interval_r) ? '0 : (interval_r - pump_r);
  assign water_dec = (water_r > in_delta) ? (water_r - in_delta) : '0;

  mpit_chan_mem #(
    .CHANNELS (CHANNELS),
    .IW       (IW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_rec  (rd_rec),
    .wr_en   (wr_en),
    .wr_addr (proc_idx_r),
    .wr_rec  (alu_res.rec)
  );

  mpit_chan_alu u_alu (
    .req      (req_r),
    .delta    (delta_r),
    .water    (water_r),
    .pump_dur (pump_r),
    .reload   (reload),
    .rec      (rd_rec),
    .res      (alu_res)
  );

  // config writes
  always_comb begin
    interval_nxt = interval_r;
    pump_nxt     = pump_r;
    if (cfg_valid && (cfg_data != '0)) begin
      if (cfg_index == mpit_pkg::CFG_INTERVAL) begin
        interval_nxt = cfg_data;
      end else if (cfg_index == mpit_pkg::CFG_PUMP) begin
        pump_nxt = cfg_data;
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    ch_nxt       = ch_r;
    ch_ok_nxt    = ch_ok_r;
    delta_nxt    = delta_r;
    ok_nxt       = ok_r;
    water_nxt    = water_r;
    pumping_nxt  = pumping_r;
    rd_idx_nxt   = rd_idx_r;
    last_nxt     = last_r;
    rd_more_nxt  = rd_more_r;
    proc_v_nxt   = proc_v_r;
    proc_idx_nxt = proc_idx_r;
    rd_en        = 1'b0;
    rd_addr      = ch_r[IW-1:0];
    wr_en        = 1'b0;
    out_load     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt     = in_req;
          ch_nxt      = in_ch;
          ch_ok_nxt   = in_ch_ok;
          delta_nxt   = in_delta;
          ok_nxt      = 1'b0;
          rd_more_nxt = 1'b1;
          proc_v_nxt  = 1'b0;
          state_nxt   = S_RPT;
          priority case (in_req)
            mpit_pkg::REQ_TICK: begin
              water_nxt  = water_dec;
              rd_idx_nxt = '0;
              last_nxt   = LAST_IDX;
              state_nxt  = S_SCAN;
            end
            mpit_pkg::REQ_TRIG, mpit_pkg::REQ_STOP: begin
              if (in_all) begin
                rd_idx_nxt = '0;
                last_nxt   = LAST_IDX;
                state_nxt  = S_SCAN;
              end else if (in_ch_ok) begin
                rd_idx_nxt = in_ch[IW-1:0];
                last_nxt   = in_ch[IW-1:0];
                state_nxt  = S_SCAN;
              end
            end
            mpit_pkg::REQ_RELOAD: begin
              if (water_r != '0) begin
                water_nxt = reload;
                ok_nxt    = 1'b1;
              end
            end
            mpit_pkg::REQ_QUERY: begin
              ok_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        // read of the next channel overlaps write-back of the current one
        if (rd_more_r) begin
          rd_en        = 1'b1;
          rd_addr      = rd_idx_r;
          proc_v_nxt   = 1'b1;
          proc_idx_nxt = rd_idx_r;
          if (rd_idx_r == last_r) begin
            rd_more_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end else begin
          proc_v_nxt = 1'b0;
        end
        if (proc_v_r) begin
          wr_en  = 1'b1;
          ok_nxt = ok_r | alu_res.ok;
          if (alu_res.water_wr) begin
            water_nxt = alu_res.water;
          end
          pumping_nxt[proc_idx_r] = (alu_res.rec.mode == mpit_pkg::MODE_MANUAL) ||
                                    (alu_res.rec.mode == mpit_pkg::MODE_AUTO);
        end
        if (!rd_more_r && !proc_v_r) begin
          rd_en     = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RPT: begin
        rd_en     = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign pumping_ext = PW'(pumping_r);
  assign rpt_mode    = ch_ok_r ? rd_rec.mode : mpit_pkg::MODE_NONE;
  assign rpt_timer   = ch_ok_r ? rd_rec.timer : '0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      water_r     <= mpit_pkg::WATER_RST;
      interval_r  <= mpit_pkg::INTERVAL_RST;
      pump_r      <= mpit_pkg::PUMP_RST;
      pumping_r   <= '0;
      rd_more_r   <= 1'b0;
      proc_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      water_r     <= water_nxt;
      interval_r  <= interval_nxt;
      pump_r      <= pump_nxt;
      pumping_r   <= pumping_nxt;
      rd_more_r   <= rd_more_nxt;
      proc_v_r    <= proc_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    ch_r       <= ch_nxt;
    ch_ok_r    <= ch_ok_nxt;
    delta_r    <= delta_nxt;
    ok_r       <= ok_nxt;
    rd_idx_r   <= rd_idx_nxt;
    last_r     <= last_nxt;
    proc_idx_r <= proc_idx_nxt;
    if (out_load) begin
      out_data_r <= {1'b0, pumping_ext[3:0], water_r, rpt_timer, rpt_mode, ok_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* test/mpit_tb_pkg.sv */
// Beat layouts and result scoreboard for the pump interval timer testbench.
package mpit_tb_pkg;
  import mpit_pkg::*;

  localparam int CH = 4;

  // Input beat, lowest field last in the packed order.
  typedef struct packed {
    logic [31:0] delta;
    logic [3:0]  chan;
    logic        all_ch;
    logic [2:0]  kind;
  } request_t;

  typedef struct packed {
    logic        pad;
    logic [3:0]  mask;
    logic [31:0] water_left;
    logic [31:0] pump_left;
    logic [1:0]  state;
    logic        ok;
  } result_t;

  class pump_scoreboard;
    logic [31:0] interval;
    logic [31:0] pump_len;
    logic [31:0] water;
    logic [1:0]  mode [CH];
    logic [31:0] pump_left [CH];
    result_t     expected_q [$];
    int          mismatches;
    int          requests;
    int          results;

    function new();
      interval = INTERVAL_RST;
      pump_len = PUMP_RST;
      water    = WATER_RST;
      for (int c = 0; c < CH; c++) begin
        mode[c]      = MODE_IDLE;
        pump_left[c] = '0;
      end
      mismatches = 0;
      requests   = 0;
      results    = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Pump time at or above the interval saturates the reload at zero.
    function logic [31:0] reload_val();
      return (pump_len >= interval) ? 32'd0 : interval - pump_len;
    endfunction

    function logic [31:0] sat_sub(logic [31:0] a, logic [31:0] b);
      return (a > b) ? a - b : 32'd0;
    endfunction

    function bit is_pumping(int c);
      return mode[c] == MODE_MANUAL || mode[c] == MODE_AUTO;
    endfunction

    function bit set_mode(int c, logic [1:0] m);
      if (m == MODE_IDLE) begin
        if (mode[c] == MODE_IDLE) return 1'b0;
        mode[c]      = MODE_IDLE;
        pump_left[c] = '0;
        water        = reload_val();
        return 1'b1;
      end
      if (mode[c] != MODE_IDLE) return 1'b0;
      if (m == MODE_AUTO) water = '0;
      pump_left[c] = pump_len;
      mode[c]      = m;
      return 1'b1;
    endfunction

    function bit apply_mode(logic all_ch, logic [3:0] ch, logic [1:0] m);
      bit any;
      any = 1'b0;
      if (all_ch) begin
        for (int c = 0; c < CH; c++)
          if (set_mode(c, m)) any = 1'b1;
        return any;
      end
      if (ch >= CH) return 1'b0;
      return set_mode(ch, m);
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] d);
      if (d == '0) return;
      if (idx == CFG_INTERVAL) interval = d;
      else if (idx == CFG_PUMP) pump_len = d;
    endfunction

    function void note_request(request_t r);
      result_t e;
      logic    ok;
      ok = 1'b0;
      case (r.kind)
        REQ_TICK: begin
          water = sat_sub(water, r.delta);
          // channels are visited in order; an auto start leaves the shared countdown
          // at zero, so later idle channels start as well unless an expiring pump reloads it
          for (int c = 0; c < CH; c++) begin
            pump_left[c] = sat_sub(pump_left[c], r.delta);
            if (mode[c] == MODE_IDLE) begin
              if (water == '0)
                if (set_mode(c, MODE_AUTO)) ok = 1'b1;
            end else if (is_pumping(c)) begin
              if (pump_left[c] == '0)
                if (set_mode(c, MODE_IDLE)) ok = 1'b1;
            end
          end
        end
        REQ_TRIG: ok = apply_mode(r.all_ch, r.chan, MODE_MANUAL);
        REQ_STOP: ok = apply_mode(r.all_ch, r.chan, MODE_IDLE);
        REQ_RELOAD: begin
          if (water != '0) begin
            water = reload_val();
            ok    = 1'b1;
          end
        end
        REQ_QUERY: ok = 1'b1;
        default: ok = 1'b0;
      endcase
      e    = '0;
      e.ok = ok;
      if (r.chan < CH) begin
        e.state     = mode[r.chan];
        e.pump_left = pump_left[r.chan];
      end else begin
        e.state     = MODE_NONE;
        e.pump_left = '0;
      end
      e.water_left = water;
      for (int c = 0; c < CH && c < 4; c++)
        e.mask[c] = is_pumping(c);
      expected_q.push_back(e);
      requests++;
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("Result beat %0d: %s expected %0h, got %0h", results, what, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      results++;
      if (expected_q.size() == 0) begin
        flag("beat with nothing pending, watering_left", '0, got.water_left);
        return;
      end
      want = expected_q.pop_front();
      if (got.ok !== want.ok) flag("ok", want.ok, got.ok);
      if (got.state !== want.state) flag("chan_state", want.state, got.state);
      if (got.pump_left !== want.pump_left) flag("chan_pump_left", want.pump_left, got.pump_left);
      if (got.water_left !== want.water_left)
        flag("watering_left", want.water_left, got.water_left);
      if (got.mask !== want.mask) flag("pumping_mask", want.mask, got.mask);
      if (got.pad !== want.pad) flag("pad bit", want.pad, got.pad);
    endfunction
  endclass

endpackage

/* test/tb_multichannel_pump_interval_timer_core.sv */
// Testbench top for the multichannel pump interval timer core.
module tb_multichannel_pump_interval_timer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mpit_pkg::*;
  import mpit_tb_pkg::*;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index  = '0;
  logic [31:0] cfg_data   = '0;

  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_left = 0;

  pump_scoreboard sb;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multichannel_pump_interval_timer_core #(.CHANNELS(CH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Receiver: random stalls, or a long hold-off while hold_left runs down.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(result_t'(out_tdata));
      if (in_tvalid && in_tready) sb.note_request(request_t'(in_tdata));
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_req(request_t r);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= r;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [7:0] idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Both registers, then a zero write that must be ignored.
  task automatic program_regs(logic [31:0] intv, logic [31:0] plen, logic [7:0] zero_idx);
    write_cfg(CFG_INTERVAL, intv);
    write_cfg(CFG_PUMP, plen);
    write_cfg(zero_idx, '0);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic request_t make_req(logic [2:0] kind, logic all_ch, logic [3:0] chan,
                                        logic [31:0] delta);
    request_t r;
    r.kind   = kind;
    r.all_ch = all_ch;
    r.chan   = chan;
    r.delta  = delta;
    return r;
  endfunction

  function automatic request_t rand_req(logic [31:0] span);
    request_t r;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 40)      r.kind = REQ_TICK;
    else if (pick < 55) r.kind = REQ_TRIG;
    else if (pick < 70) r.kind = REQ_STOP;
    else if (pick < 80) r.kind = REQ_RELOAD;
    else if (pick < 92) r.kind = REQ_QUERY;
    else                r.kind = REQ_QUERY + 3'($urandom_range(3, 1));  // unknown codes
    r.all_ch = ($urandom_range(3) == 0);
    r.chan   = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(CH - 1));
    pick = $urandom_range(19);
    if (r.kind != REQ_TICK || pick == 0) r.delta = $urandom();
    else if (pick == 1)                  r.delta = '1;
    else if (pick == 2)                  r.delta = '0;
    else                                 r.delta = $urandom_range(span);
    return r;
  endfunction

  initial begin
    logic [31:0] intv_tab [4];
    logic [31:0] pump_tab [4];
    logic [31:0] span_tab [4];
    int          idle_tab [4];
    int          stall_tab [4];
    request_t    directed [$];

    intv_tab  = '{32'd100, 32'd50, 32'd1, 32'hFFFF_FFFF};
    pump_tab  = '{32'd20, 32'hFFFF_FFFF, 32'd1, 32'h0100_0000};
    span_tab  = '{32'd30, 32'd40, 32'd2, 32'h0200_0000};
    idle_tab  = '{0, 69, 0, 36};
    stall_tab = '{0, 0, 69, 36};
    sb = new();

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed sequence under reset register values
    directed.push_back(make_req(REQ_QUERY, 1'b0, 4'd0, '0));
    directed.push_back(make_req(REQ_QUERY, 1'b0, 4'd15, '0));        // invalid channel
    directed.push_back(make_req(REQ_RELOAD, 1'b0, 4'd1, '0));
    directed.push_back(make_req(REQ_TICK, 1'b0, 4'd0, '0));
    directed.push_back(make_req(REQ_TICK, 1'b0, 4'd0, 32'd86369999)); // countdown left at 1
    directed.push_back(make_req(REQ_TRIG, 1'b0, 4'd2, '0));
    directed.push_back(make_req(REQ_TRIG, 1'b0, 4'd2, '0));           // already pumping
    directed.push_back(make_req(REQ_TRIG, 1'b0, 4'd7, '0));
    directed.push_back(make_req(REQ_STOP, 1'b0, 4'd12, '0));
    directed.push_back(make_req(REQ_STOP, 1'b0, 4'd0, '0));           // stop while idle
    directed.push_back(make_req(REQ_TICK, 1'b1, 4'd2, 32'd5000));     // idle ones go auto
    directed.push_back(make_req(REQ_RELOAD, 1'b0, 4'd0, '0));         // countdown is zero
    directed.push_back(make_req(REQ_TRIG, 1'b1, 4'd3, '0));
    directed.push_back(make_req(REQ_STOP, 1'b0, 4'd1, '0));
    directed.push_back(make_req(REQ_TICK, 1'b0, 4'd3, '1));           // every pump expires
    directed.push_back(make_req(REQ_TRIG, 1'b1, 4'd1, '0));
    directed.push_back(make_req(REQ_STOP, 1'b1, 4'd2, '0));
    directed.push_back(make_req(REQ_QUERY + 3'd1, 1'b1, 4'd15, '1));
    directed.push_back(make_req(REQ_QUERY + 3'd2, 1'b0, 4'd8, 32'h5555_5555));
    directed.push_back(make_req(REQ_QUERY + 3'd3, 1'b1, 4'd3, 32'hAAAA_AAAA));
    directed.push_back(make_req(REQ_QUERY, 1'b1, 4'd3, '1));
    directed.push_back(make_req(REQ_TICK, 1'b1, 4'd4, '0));
    foreach (directed[i]) send_req(directed[i]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      program_regs(intv_tab[ph], pump_tab[ph], ph[0] ? CFG_PUMP : CFG_INTERVAL);
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      if (ph == 0) hold_left = 250;  // output blocked; input must back up
      repeat (150) send_req(rand_req(span_tab[ph]));
      drain();
    end

    $display("Ran %0d requests (%0d results checked, %0d mismatches) over five register",
             sb.requests, sb.results, sb.mismatches);
    $display("settings, with input gaps, output stalls and a long output hold-off.");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding", sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
